// ===== hw/rtl/film_audio_sync_error_tracker_core_defines.svh =====
// Assertion macros used by the checker file of the sync error tracker.
// Each macro expands to one labeled concurrent assertion on the rising clock
// edge, disabled while reset is high.
`ifndef FILM_AUDIO_SYNC_ERROR_TRACKER_CORE_DEFINES_SVH
`define FILM_AUDIO_SYNC_ERROR_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication.
`define FASYNC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fasync checker: same-cycle property failed");

// Next-cycle implication.
`define FASYNC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fasync checker: next-cycle property failed");

`endif

// ===== hw/rtl/fasync_pkg.sv =====
// ----------------------------------------------------------------------------
// fasync_pkg
// Types and constants of the film audio sync error tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package fasync_pkg;

   // Control sequencer states, one-hot.
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DETECT = 9'b000000010,
      ST_MUL    = 9'b000000100,
      ST_ERR    = 9'b000001000,
      ST_ACC    = 9'b000010000,
      ST_LOAD   = 9'b000100000,
      ST_DIV1   = 9'b001000000,
      ST_DIV2   = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   // Pause detector codes.
   typedef enum logic [1:0] {
      NS_PLAYING = 2'd0,
      NS_PAUSE   = 2'd1,
      NS_PAUSED  = 2'd2,
      NS_RESUME  = 2'd3
   } next_state_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SAMPLE_BASE   = 2'd0;
   localparam logic [1:0] CSR_IMPS_Q8       = 2'd1;
   localparam logic [1:0] CSR_SAMPLES_FRAME = 2'd2;
   localparam logic [1:0] CSR_PAUSE_TIMEOUT = 2'd3;

   // Configuration reset values.
   localparam logic [31:0] RST_SAMPLE_BASE   = 32'd0;
   localparam logic [23:0] RST_IMPS_Q8       = 24'd256;
   localparam logic [15:0] RST_SAMPLES_FRAME = 16'd1;
   localparam logic [15:0] RST_PAUSE_TIMEOUT = 16'd123;

   // Last step indexes of the serial units (counter is five bits wide).
   localparam logic [4:0] MUL_LAST = 5'd23;
   localparam logic [4:0] DIV_LAST = 5'd31;

endpackage

`default_nettype wire

// ===== hw/rtl/fasync_ram.sv =====
// ----------------------------------------------------------------------------
// fasync_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fasync_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 6,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/film_audio_sync_error_tracker_core.sv =====
// ----------------------------------------------------------------------------
// film_audio_sync_error_tracker_core
// Per-tick audio sync error tracker: sliding-average sample error, frame
// offset and pause detection.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Word
//   req_*     in         req_valid/req_ready   one control tick
//   rsp_*     out        rsp_valid/rsp_ready   avg error, frame offset, state
//   csr_*     in         csr_wr_en             register index and data
//
// A running tick goes from acceptance to a registered result through the
// detect step, the bit-serial multiplier, the error, window update and divider
// load steps and two passes of the shared one-bit-per-cycle divider.
// A tick with the decoder paused goes from the detect step to the final step.
// Synchronous reset clears the window (through per-entry valid bits) and all
// tracker state. req_ready is high only between ticks; a result waiting on a
// low rsp_ready holds the next tick at its final step.
//
`default_nettype none

module film_audio_sync_error_tracker_core
   import fasync_pkg::*;
#(
   parameter int WINDOW = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input words
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_sample_count,
   input  wire logic [31:0] req_impulse_count,
   input  wire logic signed [13:0] req_offset_imps,
   input  wire logic        req_decoder_paused,
   input  wire logic [31:0] req_now_ms,
   // Result words
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_avg_error,
   output logic signed [31:0] rsp_frame_offset,
   output logic [1:0]       rsp_next_state,
   // Configuration writes
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
   localparam logic [15:0] WINDOW_DIV = 16'(WINDOW);

   // Control registers.
   state_type         state_ff, state_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [WINDOW-1:0] vld_ff, vld_in;

   // Configuration registers.
   logic [31:0] base_ff, base_in;
   logic [23:0] q8_ff, q8_in;
   logic [15:0] spf_ff, spf_in;
   logic [15:0] timeout_ff, timeout_in;

   // Tracker state.
   logic [31:0] total_ff, total_in;
   logic [31:0] prev_sum_ff, prev_sum_in;
   logic [31:0] last_ms_ff, last_ms_in;
   logic [31:0] held_avg_ff, held_avg_in;
   logic [31:0] held_frames_ff, held_frames_in;

   // Latched tick and datapath.
   logic [31:0] sum_ff, sum_in;
   logic [31:0] samples_ff, samples_in;
   logic [31:0] now_ff, now_in;
   logic        paused_ff, paused_in;
   logic [1:0]  ns_ff, ns_in;
   logic [56:0] prod_ff, prod_in;
   logic [31:0] err_ff, err_in;
   logic [31:0] div_q_ff, div_q_in;
   logic [15:0] div_rem_ff, div_rem_in;
   logic [15:0] div_d_ff, div_d_in;
   logic        div_neg_ff, div_neg_in;

   // Output registers.
   logic [31:0] out_avg_ff, out_avg_in;
   logic [31:0] out_frames_ff, out_frames_in;
   logic [1:0]  out_ns_ff, out_ns_in;

   // Window memory ports.
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_rd_addr;
   logic [31:0]       ram_rd_data;

   // Datapath helpers.
   logic [SLOT_W-1:0] slot_next;
   logic [32:0]       mul_add;
   logic [16:0]       rem_shift;
   logic              div_ge;
   logic [16:0]       rem_sub;
   logic [31:0]       div_q_next;
   logic [31:0]       old_entry;
   logic [31:0]       elapsed;
   logic              sum_changed;

   fasync_ram #(
      .WIDTH (32),
      .DEPTH (WINDOW)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (err_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Slot advance and the serial arithmetic steps.
   always_comb begin
      slot_next   = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);
      mul_add     = prod_ff[56:24] + (prod_ff[0] ? {1'b0, sum_ff} : 33'd0);
      rem_shift   = {div_rem_ff, div_q_ff[31]};
      div_ge      = rem_shift >= {1'b0, div_d_ff};
      rem_sub     = div_ge ? (rem_shift - {1'b0, div_d_ff}) : rem_shift;
      div_q_next  = {div_q_ff[30:0], div_ge};
      old_entry   = vld_ff[slot_ff] ? ram_rd_data : 32'd0;
      elapsed     = now_ff - last_ms_ff;
      sum_changed = sum_ff != prev_sum_ff;
      ram_rd_addr = slot_next;
      ram_wr_en   = (state_ff == ST_ACC);
   end

   // Sequencer and next values of all registers.
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      slot_in        = slot_ff;
      vld_in         = vld_ff;
      base_in        = base_ff;
      q8_in          = q8_ff;
      spf_in         = spf_ff;
      timeout_in     = timeout_ff;
      total_in       = total_ff;
      prev_sum_in    = prev_sum_ff;
      last_ms_in     = last_ms_ff;
      held_avg_in    = held_avg_ff;
      held_frames_in = held_frames_ff;
      sum_in         = sum_ff;
      samples_in     = samples_ff;
      now_in         = now_ff;
      paused_in      = paused_ff;
      ns_in          = ns_ff;
      prod_in        = prod_ff;
      err_in         = err_ff;
      div_q_in       = div_q_ff;
      div_rem_in     = div_rem_ff;
      div_d_in       = div_d_ff;
      div_neg_in     = div_neg_ff;
      out_avg_in     = out_avg_ff;
      out_frames_in  = out_frames_ff;
      out_ns_in      = out_ns_ff;

      // The taken result frees the output register.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes.
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SAMPLE_BASE:   base_in    = csr_wdata;
            CSR_IMPS_Q8:       q8_in      = csr_wdata[23:0];
            CSR_SAMPLES_FRAME: spf_in     = csr_wdata[15:0];
            CSR_PAUSE_TIMEOUT: timeout_in = csr_wdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         // Take a tick and form the impulse sum.
         ST_IDLE: begin
            if (req_valid) begin
               sum_in     = req_impulse_count + {{18{req_offset_imps[13]}}, req_offset_imps};
               samples_in = req_sample_count;
               now_in     = req_now_ms;
               paused_in  = req_decoder_paused;
               state_in   = ST_DETECT;
            end
         end
         // Pause detector; start the multiplier on a running tick.
         ST_DETECT: begin
            prod_in = {33'd0, q8_ff};
            cnt_in  = '0;
            if (paused_ff) begin
               ns_in    = sum_changed ? NS_RESUME : NS_PAUSED;
               state_in = ST_DONE;
            end else begin
               if (sum_changed) begin
                  prev_sum_in = sum_ff;
                  last_ms_in  = now_ff;
                  ns_in       = NS_PLAYING;
               end else if (elapsed >= {16'd0, timeout_ff}) begin
                  ns_in = NS_PAUSE;
               end else begin
                  ns_in = NS_PLAYING;
               end
               state_in = ST_MUL;
            end
         end
         // Shift-add multiply, one factor bit per cycle.
         ST_MUL: begin
            prod_in = {1'b0, mul_add, prod_ff[23:1]};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_ERR;
            end
         end
         // Sample error and window read at the next slot.
         ST_ERR: begin
            err_in   = (samples_ff - base_ff) - prod_ff[39:8];
            slot_in  = slot_next;
            state_in = ST_ACC;
         end
         // Replace the oldest entry and update the running total.
         ST_ACC: begin
            total_in        = total_ff - old_entry + err_ff;
            vld_in[slot_ff] = 1'b1;
            state_in        = ST_LOAD;
         end
         // Load the divider with the magnitude of the total.
         ST_LOAD: begin
            div_neg_in = total_ff[31];
            div_q_in   = total_ff[31] ? (32'd0 - total_ff) : total_ff;
            div_rem_in = '0;
            div_d_in   = WINDOW_DIV;
            cnt_in     = '0;
            state_in   = ST_DIV1;
         end
         // Average: total over the window depth.
         ST_DIV1: begin
            div_q_in   = div_q_next;
            div_rem_in = rem_sub[15:0];
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               // The average keeps the total's sign, so its magnitude is the quotient.
               held_avg_in = div_neg_ff ? (32'd0 - div_q_next) : div_q_next;
               div_q_in    = div_q_next;
               div_rem_in  = '0;
               div_d_in    = (spf_ff == 16'd0) ? 16'd1 : spf_ff;
               state_in    = ST_DIV2;
            end
         end
         // Frame offset: average over samples per frame.
         ST_DIV2: begin
            div_q_in   = div_q_next;
            div_rem_in = rem_sub[15:0];
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               held_frames_in = div_neg_ff ? (32'd0 - div_q_next) : div_q_next;
               state_in       = ST_DONE;
            end
         end
         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_avg_in    = held_avg_ff;
               out_frames_in = held_frames_ff;
               out_ns_in     = ns_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and tracker state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         slot_ff        <= '0;
         vld_ff         <= '0;
         base_ff        <= RST_SAMPLE_BASE;
         q8_ff          <= RST_IMPS_Q8;
         spf_ff         <= RST_SAMPLES_FRAME;
         timeout_ff     <= RST_PAUSE_TIMEOUT;
         total_ff       <= '0;
         prev_sum_ff    <= '0;
         last_ms_ff     <= '0;
         held_avg_ff    <= '0;
         held_frames_ff <= '0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         slot_ff        <= slot_in;
         vld_ff         <= vld_in;
         base_ff        <= base_in;
         q8_ff          <= q8_in;
         spf_ff         <= spf_in;
         timeout_ff     <= timeout_in;
         total_ff       <= total_in;
         prev_sum_ff    <= prev_sum_in;
         last_ms_ff     <= last_ms_in;
         held_avg_ff    <= held_avg_in;
         held_frames_ff <= held_frames_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sum_ff        <= sum_in;
      samples_ff    <= samples_in;
      now_ff        <= now_in;
      paused_ff     <= paused_in;
      ns_ff         <= ns_in;
      prod_ff       <= prod_in;
      err_ff        <= err_in;
      div_q_ff      <= div_q_in;
      div_rem_ff    <= div_rem_in;
      div_d_ff      <= div_d_in;
      div_neg_ff    <= div_neg_in;
      out_avg_ff    <= out_avg_in;
      out_frames_ff <= out_frames_in;
      out_ns_ff     <= out_ns_in;
   end

   // Ports.
   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_avg_error    = out_avg_ff;
   assign rsp_frame_offset = out_frames_ff;
   assign rsp_next_state   = out_ns_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fasync_checker.sv =====
// ----------------------------------------------------------------------------
// fasync_checker
// Port-level checks of the sync error tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "film_audio_sync_error_tracker_core_defines.svh"

module fasync_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_avg_error,
   input wire logic [31:0] rsp_frame_offset,
   input wire logic [1:0]  rsp_next_state
);

   // A stalled result stays offered.
   `FASYNC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A stalled result keeps its word.
   `FASYNC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_avg_error) && $stable(rsp_frame_offset) && $stable(rsp_next_state))

   // One tick at a time: an accepted word closes the input until it is done.
   `FASYNC_ASSERT_NEXT(a_one_tick, clock, reset, req_valid && req_ready, !req_ready)

   // Frame offset never has the opposite sign of the averaged error.
   `FASYNC_ASSERT_NOW(a_frame_sign, clock, reset, rsp_valid, (rsp_frame_offset == 32'd0) || (rsp_frame_offset[31] == rsp_avg_error[31]))

endmodule

bind film_audio_sync_error_tracker_core fasync_checker u_fasync_checker (.*);

`default_nettype wire

// ===== verif/tb_film_audio_sync_error_tracker_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_film_audio_sync_error_tracker_core
// Self-checking bench for the sync error tracker. A queue of control ticks
// feeds a valid/ready driver, and a tracker model in the bench predicts the
// averaged error, frame offset and pause code of every accepted word. A short
// directed run covers edge cases, then playback sessions with random content
// and random noise run under several register settings.
// ----------------------------------------------------------------------------

module tb_film_audio_sync_error_tracker_core;
   import fasync_pkg::*;

   localparam int TRACK_WINDOW  = 6;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 200;
   localparam int LONG_STALL_AT = 200;
   localparam int LONG_STALL    = 600;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic [31:0]        sample_count;
      logic [31:0]        impulse_count;
      logic signed [13:0] offset_imps;
      logic               decoder_paused;
      logic [31:0]        now_ms;
   } tick_type;

   typedef struct {
      logic signed [31:0] avg_error;
      logic signed [31:0] frame_offset;
      next_state_type     next_state;
   } result_type;

   // Clock, reset and block ports.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [31:0]         req_sample_count = '0;
   logic [31:0]         req_impulse_count = '0;
   logic signed [13:0]  req_offset_imps = '0;
   logic                req_decoder_paused = 1'b0;
   logic [31:0]         req_now_ms = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic signed [31:0]  rsp_avg_error;
   logic signed [31:0]  rsp_frame_offset;
   logic [1:0]          rsp_next_state;
   logic                csr_wr_en = 1'b0;
   logic [1:0]          csr_index = '0;
   logic [31:0]         csr_wdata = '0;

   // Tick queues and bookkeeping.
   tick_type   pending_ticks[$];
   result_type expected_results[$];
   tick_type   offered_tick;
   int      ticks_queued = 0;
   int      ticks_accepted = 0;
   int      results_seen = 0;
   int      mismatch_count = 0;
   int      send_gap = 0;
   int      recv_wait = 0;
   int      cycle_count = 0;

   // Register copies, as after reset.
   logic [31:0] cfg_sample_base   = RST_SAMPLE_BASE;
   logic [23:0] cfg_imps_q8       = RST_IMPS_Q8;
   logic [15:0] cfg_samples_frame = RST_SAMPLES_FRAME;
   logic [15:0] cfg_pause_timeout = RST_PAUSE_TIMEOUT;

   // Tracker state, all zero after reset.
   logic [31:0]        trk_window [TRACK_WINDOW] = '{default: '0};
   logic [31:0]        trk_total = '0;
   int                 trk_slot = 0;
   logic [31:0]        trk_prev_sum = '0;
   logic [31:0]        trk_last_change = '0;
   logic signed [31:0] trk_held_avg = '0;
   logic signed [31:0] trk_held_frames = '0;

   film_audio_sync_error_tracker_core #(
      .WINDOW(TRACK_WINDOW)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample_count   (req_sample_count),
      .req_impulse_count  (req_impulse_count),
      .req_offset_imps    (req_offset_imps),
      .req_decoder_paused (req_decoder_paused),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_avg_error      (rsp_avg_error),
      .rsp_frame_offset   (rsp_frame_offset),
      .rsp_next_state     (rsp_next_state),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #1 clock = ~clock;

   // Advance the tracker by one tick and return the word it should produce.
   function automatic result_type track_tick(input tick_type t);
      result_type  r;
      logic [31:0] imp_sum;
      logic [31:0] desired;
      logic [31:0] sample_err;
      logic [31:0] elapsed;
      logic [55:0] product;
      logic [15:0] divisor;
      imp_sum = t.impulse_count + {{18{t.offset_imps[13]}}, t.offset_imps};
      // The window only moves while the decoder runs; otherwise the held values repeat.
      if (!t.decoder_paused) begin
         product = {24'd0, imp_sum} * {32'd0, cfg_imps_q8};
         desired = product[39:8];
         sample_err = t.sample_count - cfg_sample_base - desired;
         divisor = (cfg_samples_frame == 16'd0) ? 16'd1 : cfg_samples_frame;
         trk_slot = (trk_slot == TRACK_WINDOW - 1) ? 0 : trk_slot + 1;
         trk_total = trk_total - trk_window[trk_slot] + sample_err;
         trk_window[trk_slot] = sample_err;
         // Signed division truncates toward zero.
         trk_held_avg = $signed(trk_total) / TRACK_WINDOW;
         trk_held_frames = trk_held_avg / $signed({16'd0, divisor});
      end
      // Pause detection: a paused decoder leaves the detector state alone.
      if (t.decoder_paused) begin
         r.next_state = (imp_sum != trk_prev_sum) ? NS_RESUME : NS_PAUSED;
      end else if (imp_sum != trk_prev_sum) begin
         trk_prev_sum = imp_sum;
         trk_last_change = t.now_ms;
         r.next_state = NS_PLAYING;
      end else begin
         elapsed = t.now_ms - trk_last_change;
         r.next_state = (elapsed >= {16'd0, cfg_pause_timeout}) ? NS_PAUSE : NS_PLAYING;
      end
      r.avg_error = trk_held_avg;
      r.frame_offset = trk_held_frames;
      return r;
   endfunction

   task automatic add_tick(input logic [31:0] sample_count, input logic [31:0] impulse_count,
                           input logic [13:0] offset_imps, input logic decoder_paused,
                           input logic [31:0] now_ms);
      tick_type t;
      t.sample_count = sample_count;
      t.impulse_count = impulse_count;
      t.offset_imps = offset_imps;
      t.decoder_paused = decoder_paused;
      t.now_ms = now_ms;
      pending_ticks.push_back(t);
      ticks_queued++;
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_SAMPLE_BASE:   cfg_sample_base = data;
         CSR_IMPS_Q8:       cfg_imps_q8 = data[23:0];
         CSR_SAMPLES_FRAME: cfg_samples_frame = data[15:0];
         CSR_PAUSE_TIMEOUT: cfg_pause_timeout = data[15:0];
         default: ;
      endcase
   endtask

   // Write all four registers back to back; only called while the block is idle.
   task automatic apply_settings(input logic [31:0] base, input logic [23:0] q8,
                                 input logic [15:0] spf, input logic [15:0] timeout);
      write_reg(CSR_SAMPLE_BASE, base);
      write_reg(CSR_IMPS_Q8, {8'd0, q8});
      write_reg(CSR_SAMPLES_FRAME, {16'd0, spf});
      write_reg(CSR_PAUSE_TIMEOUT, {16'd0, timeout});
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Wait until every queued tick is accepted, every word has come back and
   // the block is ready for the next tick.
   task automatic wait_idle();
      while (ticks_accepted != ticks_queued || expected_results.size() != 0 || !req_ready)
         @(posedge clock);
   endtask

   // A playback session: impulses creep forward, samples track the desired
   // count with some jitter, and the decoder pauses now and then. About one
   // tick in ten is pure noise.
   task automatic play_session(input int n_ticks, input logic [31:0] base,
                               input logic [23:0] q8, input logic [15:0] timeout);
      logic [31:0] imps;
      logic [31:0] now;
      logic [31:0] imp_sum;
      logic [31:0] desired;
      logic [31:0] jitter;
      logic [55:0] product;
      logic [13:0] off;
      logic        paused;
      imps = $urandom;
      now = $urandom;
      off = 14'($urandom_range(0, 16383));
      paused = 1'b0;
      for (int i = 0; i < n_ticks; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            add_tick($urandom, $urandom, 14'($urandom), 1'($urandom), $urandom);
         end else begin
            if ($urandom_range(0, 14) == 0) paused = ~paused;
            if (paused) imps = imps + 32'($urandom_range(0, 5) == 0);
            else imps = imps + $urandom_range(0, 3);
            // Occasional long jumps in time let the pause timeout expire.
            if ($urandom_range(0, 19) == 0) now = now + $urandom_range(0, 2 * timeout + 2);
            else now = now + $urandom_range(0, 250);
            if ($urandom_range(0, 24) == 0) off = 14'($urandom_range(0, 16383));
            imp_sum = imps + {{18{off[13]}}, off};
            product = {24'd0, imp_sum} * {32'd0, q8};
            desired = product[39:8];
            jitter = $urandom_range(0, 4000) - 2000;
            add_tick(base + desired + jitter, imps, off, paused, now);
         end
      end
   endtask

   // Driver: offers one word at a time, with a random gap after each, but none in every third run of sixty words.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(track_tick(offered_tick));
            ticks_accepted++;
            send_gap = (((ticks_accepted / 60) % 3) == 1) ? 0 : $urandom_range(0, 4);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
               offered_tick = pending_ticks.pop_front();
               req_sample_count <= offered_tick.sample_count;
               req_impulse_count <= offered_tick.impulse_count;
               req_offset_imps <= offered_tick.offset_imps;
               req_decoder_paused <= offered_tick.decoder_paused;
               req_now_ms <= offered_tick.now_ms;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result word against the oldest expectation. The
   // stall drawn for a word is counted while that word is being offered; once
   // the stall is a long one, so that the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected result word: avg %0d frames %0d state %0d",
                           rsp_avg_error, rsp_frame_offset, rsp_next_state);
            end else begin
               result_type exp_word;
               exp_word = expected_results.pop_front();
               if (rsp_avg_error !== exp_word.avg_error ||
                   rsp_frame_offset !== exp_word.frame_offset ||
                   rsp_next_state !== exp_word.next_state) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("word %0d: expected avg %0d frames %0d state %0d, got avg %0d frames %0d state %0d",
                              results_seen, exp_word.avg_error, exp_word.frame_offset,
                              exp_word.next_state, rsp_avg_error, rsp_frame_offset,
                              rsp_next_state);
               end
            end
            results_seen++;
            if (results_seen == LONG_STALL_AT) recv_wait = LONG_STALL;
            else if (((results_seen / 50) % 3) == 2) recv_wait = 0;
            else recv_wait = $urandom_range(0, 4);
         end else if (rsp_valid && recv_wait > 0) begin
            recv_wait--;
         end
         rsp_ready <= (recv_wait == 0);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_film_audio_sync_error_tracker_core failed");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: timeout boundary, pause codes, wrap of sums and time.
      add_tick(32'd0, 32'd0, 14'h0000, 1'b0, 32'd0);
      add_tick(32'd0, 32'd0, 14'h0000, 1'b0, 32'd122);
      add_tick(32'd0, 32'd0, 14'h0000, 1'b0, 32'd123);
      add_tick(32'd0, 32'd0, 14'h0000, 1'b1, 32'd500);
      add_tick(32'd0, 32'd5, 14'h0000, 1'b1, 32'd501);
      add_tick(32'hFFFFFFFF, 32'hFFFFFFFF, 14'h0001, 1'b0, 32'hFFFFFFF0);
      add_tick(32'd0, 32'hFFFFFFFF, 14'h2000, 1'b0, 32'd5);
      add_tick(32'h80000000, 32'd0, 14'h1FFF, 1'b0, 32'd10);
      add_tick(32'd0, 32'h7FFFFFFF, 14'h0000, 1'b0, 32'd2);
      add_tick(32'd0, 32'h7FFFFFFF, 14'h0000, 1'b0, 32'd1);
      add_tick(32'hAAAAAAAA, 32'h55555555, 14'h2AAA, 1'b0, 32'hAAAAAAAA);
      add_tick(32'h55555555, 32'hAAAAAAAA, 14'h1555, 1'b0, 32'h55555555);
      wait_idle();

      // Widest factor, zero divider and zero timeout.
      apply_settings(32'hFFFFFFFF, 24'hFFFFFF, 16'd0, 16'd0);
      add_tick(32'd0, 32'd100, 14'h0000, 1'b0, 32'd7);
      add_tick(32'd0, 32'd100, 14'h0000, 1'b0, 32'd7);
      add_tick(32'hFFFFFFFF, 32'hFFFFFFFF, 14'h3FFF, 1'b0, 32'd8);
      add_tick(32'd123456, 32'hFFFFFFFF, 14'h3FFF, 1'b1, 32'd9);
      add_tick(32'h80000000, 32'd1, 14'h0000, 1'b0, 32'd9);
      wait_idle();

      // Zero factor, widest divider and timeout.
      apply_settings(32'd0, 24'd0, 16'hFFFF, 16'hFFFF);
      add_tick(32'd5000, 32'd7, 14'h0003, 1'b0, 32'd0);
      add_tick(32'd5000, 32'd7, 14'h0003, 1'b0, 32'd65534);
      add_tick(32'd5000, 32'd7, 14'h0003, 1'b0, 32'd65535);
      add_tick(32'hFFFFFFFF, 32'd9, 14'h0001, 1'b1, 32'd70000);

      // Random sessions under a range of settings.
      for (int phase = 0; phase < 5; phase++) begin
         wait_idle();
         case (phase)
            0: apply_settings($urandom, 24'($urandom_range(256, 600000)), 16'd2000, 16'd123);
            1: apply_settings(32'hFFFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
            2: apply_settings($urandom, 24'($urandom), 16'($urandom_range(1, 65535)),
                              16'($urandom));
            3: apply_settings(32'd0, 24'd0, 16'd1, 16'd0);
            default: apply_settings($urandom, 24'($urandom), 16'($urandom_range(1, 40)),
                                    16'($urandom_range(50, 400)));
         endcase
         play_session(130, cfg_sample_base, cfg_imps_q8, cfg_pause_timeout);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("tb_film_audio_sync_error_tracker_core passed");
      else
         $display("tb_film_audio_sync_error_tracker_core failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/fasync_pkg.sv
hw/rtl/fasync_ram.sv
hw/rtl/film_audio_sync_error_tracker_core.sv
hw/rtl/fasync_checker.sv
verif/tb_film_audio_sync_error_tracker_core.sv
